// ===== sv/mlr_pkg.sv =====
`timescale 1ns / 1ps
package mlr_pkg;
    localparam int EVENT_SLOTS   = 16384;
    localparam int TIME_BITS     = 24;
    localparam int PLAY_PER_TICK = 16;
    localparam int ADDR_BITS     = $clog2(EVENT_SLOTS);
    localparam int CNT_BITS      = ADDR_BITS + 1;
    localparam int PLAY_BITS     = $clog2(PLAY_PER_TICK + 1);
    localparam int QDEPTH        = 2;

    typedef enum logic [2:0] {
        REQ_MSG   = 3'd0,
        REQ_TICK  = 3'd1,
        REQ_START = 3'd2,
        REQ_STOP  = 3'd3,
        REQ_HALT  = 3'd4
    } req_t;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_ARMED = 2'd1,
        MODE_REC   = 2'd2,
        MODE_LOOP  = 2'd3
    } mode_t;

    localparam logic [1:0] KIND_FWD    = 2'd0;
    localparam logic [1:0] KIND_PLAY   = 2'd1;
    localparam logic [1:0] KIND_ALLOFF = 2'd2;
    localparam logic [1:0] KIND_REPORT = 2'd3;

    localparam logic [3:0] TY_OFF  = 4'd8;
    localparam logic [3:0] TY_ON   = 4'd9;
    localparam logic [3:0] TY_CC   = 4'd11;
    localparam logic [6:0] CC_EXPR    = 7'd11;
    localparam logic [6:0] CC_SUSTAIN = 7'd64;
    localparam logic [6:0] CC_ALLOFF  = 7'd123;

    // classified command handed from front to back
    typedef enum logic [2:0] {
        CMD_FWD,
        CMD_TICK,
        CMD_START,
        CMD_STOP,
        CMD_HALT
    } cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [3:0] ty;
        logic [3:0] ch;
        logic [6:0] a;
        logic [6:0] b;
        logic       is_on;
        logic       is_off;
    } job_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] ty;
        logic [3:0] ch;
        logic [6:0] a;
        logic [6:0] b;
        logic       started;
        logic [1:0] mode;
        logic       last;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALLOFF,
        ST_PLAY_RD,
        ST_PLAY_CHK,
        ST_PLAY_END
    } state_t;
endpackage

// ===== sv/mlr_front.sv =====
`timescale 1ns / 1ps
module mlr_front
    import mlr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  req,
    input  logic [3:0]  ty,
    input  logic [3:0]  ch,
    input  logic [6:0]  a,
    input  logic [6:0]  b,
    output logic        q_valid,
    input  logic        q_ready,
    output job_t        q_job
);
    job_t                     mem_reg [QDEPTH];
    logic [$clog2(QDEPTH):0]  cnt_reg, cnt_next;
    logic [$clog2(QDEPTH)-1:0] wp_reg, rp_reg;
    logic  push, pop, keep;
    job_t  j;

    always_comb
    begin
        j = '0;
        j.ty = ty;
        j.ch = ch;
        j.a  = a;
        j.b  = b;
        j.is_on  = (ty == TY_ON) && (b != 7'd0);
        j.is_off = (ty == TY_OFF) || ((ty == TY_ON) && (b == 7'd0));
        keep = 1'b1;
        case (req)
            REQ_MSG:   begin j.cmd = CMD_FWD;
                       keep = !((ty == TY_CC) && (a == CC_EXPR) && (b == 7'd0)); end
            REQ_TICK:  j.cmd = CMD_TICK;
            REQ_START: j.cmd = CMD_START;
            REQ_STOP:  j.cmd = CMD_STOP;
            REQ_HALT:  j.cmd = CMD_HALT;
            default:   begin j.cmd = CMD_TICK; keep = 1'b0; end
        endcase
    end

    assign in_ready = (cnt_reg != QDEPTH[$clog2(QDEPTH):0]);
    assign push     = in_valid && in_ready && keep;
    assign q_valid  = (cnt_reg != '0);
    assign pop      = q_valid && q_ready;
    assign q_job    = mem_reg[rp_reg];
    assign cnt_next = cnt_reg + {{$clog2(QDEPTH){1'b0}}, push}
                      - {{$clog2(QDEPTH){1'b0}}, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            wp_reg  <= '0;
            rp_reg  <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop)  rp_reg <= rp_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wp_reg] <= j;
    end

    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QDEPTH) else $error("queue overflow");
    a_nopop: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> !q_valid) else $error("pop from empty");
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == QDEPTH) |-> !in_ready) else $error("push when full");
endmodule

// ===== sv/mlr_back.sv =====
`timescale 1ns / 1ps
module mlr_back
    import mlr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [3:0]  loop_ch,
    input  logic        q_valid,
    output logic        q_ready,
    input  job_t        q_job,
    output logic        o_valid,
    input  logic        o_ready,
    output res_t        o_res
);
    localparam logic [TIME_BITS-1:0] TMAX = '1;

    logic [TIME_BITS+15:0] store [EVENT_SLOTS];
    logic [TIME_BITS+15:0] rd_reg;

    state_t                st_reg, st_next;
    mode_t                 mode_reg, mode_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [TIME_BITS-1:0]  el_reg, el_next, len_reg, len_next, pos_reg, pos_next;
    logic [CNT_BITS-1:0]   pi_reg, pi_next;
    logic [4:0]            ch_reg, ch_next;  // all-off index: channel and which cc
    logic [PLAY_BITS-1:0]  np_reg, np_next;
    logic                  due_reg, due_next;
    logic                  ov_reg, ov_next;
    res_t                  or_reg, or_next;
    res_t                  pw_reg, pw_next;  // played note held until the next is known
    logic                  pv_reg, pv_next;
    logic                  wr_en, rd_en;
    logic [ADDR_BITS-1:0]  wr_addr;
    logic [TIME_BITS+15:0] wr_data;
    logic                  take, ofree;
    logic                  more;
    logic [TIME_BITS:0]    pos_inc;

    assign ofree   = !ov_reg || o_ready;
    assign o_valid = ov_reg;
    assign o_res   = or_reg;
    assign q_ready = (st_reg == ST_IDLE) && ofree;
    assign take    = q_valid && q_ready;
    assign pos_inc = {1'b0, pos_reg} + 1'b1;
    assign more    = (np_reg < PLAY_PER_TICK[PLAY_BITS-1:0]) && (pi_reg < cnt_reg);

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE:
                if (take)
                begin
                    case (q_job.cmd)
                        CMD_START, CMD_HALT: st_next = ST_ALLOFF;
                        CMD_TICK: if (mode_reg == MODE_LOOP) st_next = ST_PLAY_RD;
                        default: st_next = ST_IDLE;
                    endcase
                end
            ST_ALLOFF:   if (ofree && ch_reg == 5'd31) st_next = ST_IDLE;
            ST_PLAY_RD:  st_next = more ? ST_PLAY_CHK : ST_PLAY_END;
            ST_PLAY_CHK:
                if (!due_reg && rd_reg[TIME_BITS+15:16] > pos_reg) st_next = ST_PLAY_END;
                else if (!pv_reg || ofree) st_next = ST_PLAY_RD;
            ST_PLAY_END: if (!pv_reg || ofree) st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        mode_next = mode_reg; cnt_next = cnt_reg; el_next = el_reg;
        len_next = len_reg; pos_next = pos_reg; pi_next = pi_reg;
        ch_next = ch_reg; np_next = np_reg; due_next = due_reg;
        ov_next = ov_reg && !o_ready; or_next = or_reg;
        pw_next = pw_reg; pv_next = pv_reg;
        wr_en = 1'b0; wr_addr = cnt_reg[ADDR_BITS-1:0];
        wr_data = {el_reg, q_job.a, q_job.b, 2'b00};
        rd_en = 1'b0;
        case (st_reg)
            ST_IDLE:
                if (take)
                begin
                    case (q_job.cmd)
                        CMD_FWD:
                        begin
                            or_next = '0;
                            or_next.kind = KIND_FWD;
                            or_next.ty = q_job.ty;
                            or_next.ch = (mode_reg == MODE_ARMED || mode_reg == MODE_REC)
                                         ? loop_ch : q_job.ch;
                            or_next.a = q_job.a;
                            or_next.b = q_job.b;
                            or_next.last = 1'b1;
                            if ((q_job.is_on || q_job.is_off) && cnt_reg < EVENT_SLOTS[CNT_BITS-1:0]
                                && (mode_reg == MODE_REC || (mode_reg == MODE_ARMED && q_job.is_on)))
                            begin
                                wr_en = 1'b1;
                                if (mode_reg == MODE_ARMED)
                                begin
                                    wr_data = {{TIME_BITS{1'b0}}, q_job.a, q_job.b, 2'b00};
                                    el_next = '0;
                                    mode_next = MODE_REC;
                                end
                                wr_data[1] = q_job.is_on;
                                cnt_next = cnt_reg + 1'b1;
                            end
                            or_next.mode = mode_next;
                            ov_next = 1'b1;
                        end
                        CMD_TICK:
                            if (mode_reg == MODE_REC)
                            begin
                                if (el_reg != TMAX) el_next = el_reg + 1'b1;
                            end
                            else if (mode_reg == MODE_LOOP)
                            begin
                                np_next = '0;
                                due_next = (pos_inc >= {1'b0, len_reg});
                            end
                        CMD_START:
                        begin
                            cnt_next = '0; len_next = '0; el_next = '0;
                            pos_next = '0; pi_next = '0;
                            mode_next = MODE_ARMED; ch_next = '0;
                        end
                        CMD_HALT:
                        begin
                            mode_next = MODE_IDLE; ch_next = '0;
                        end
                        CMD_STOP:
                        begin
                            or_next = '0;
                            or_next.kind = KIND_REPORT;
                            or_next.last = 1'b1;
                            if (mode_reg == MODE_ARMED) mode_next = MODE_IDLE;
                            else if (mode_reg == MODE_REC)
                            begin
                                len_next = el_reg;
                                if (cnt_reg == '0 || el_reg == '0) mode_next = MODE_IDLE;
                                else
                                begin
                                    pos_next = '0; pi_next = '0;
                                    mode_next = MODE_LOOP;
                                    or_next.started = 1'b1;
                                end
                            end
                            or_next.mode = mode_next;
                            ov_next = 1'b1;
                        end
                        default: ;
                    endcase
                end
            ST_ALLOFF:
                if (ofree)
                begin
                    or_next = '0;
                    or_next.kind = KIND_ALLOFF;
                    or_next.ty = TY_CC;
                    or_next.ch = ch_reg[4:1];
                    or_next.a = ch_reg[0] ? CC_ALLOFF : CC_SUSTAIN;
                    or_next.mode = mode_reg;
                    or_next.last = (ch_reg == 5'd31);
                    ov_next = 1'b1;
                    ch_next = ch_reg + 1'b1;
                end
            ST_PLAY_RD: rd_en = more;
            ST_PLAY_CHK:
                if ((due_reg || rd_reg[TIME_BITS+15:16] <= pos_reg) && (!pv_reg || ofree))
                begin
                    // another note follows, so the held one is not the last
                    if (pv_reg)
                    begin
                        or_next = pw_reg;
                        ov_next = 1'b1;
                    end
                    pw_next = '0;
                    pw_next.kind = KIND_PLAY;
                    pw_next.ty = rd_reg[1] ? TY_ON : TY_OFF;
                    pw_next.ch = loop_ch;
                    pw_next.a = rd_reg[15:9];
                    pw_next.b = rd_reg[1] ? rd_reg[8:2] : 7'd0;
                    pw_next.mode = mode_reg;
                    pv_next = 1'b1;
                    np_next = np_reg + 1'b1;
                    pi_next = pi_reg + 1'b1;
                end
            ST_PLAY_END:
                if (!pv_reg || ofree)
                begin
                    // mark the last played note, then advance the loop clock
                    if (pv_reg)
                    begin
                        or_next = pw_reg;
                        or_next.last = 1'b1;
                        ov_next = 1'b1;
                        pv_next = 1'b0;
                    end
                    if (pos_inc >= {1'b0, len_reg})
                    begin
                        pos_next = '0; pi_next = '0;
                    end
                    else pos_next = pos_inc[TIME_BITS-1:0];
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE; mode_reg <= MODE_IDLE; cnt_reg <= '0;
            el_reg <= '0; len_reg <= '0; pos_reg <= '0; pi_reg <= '0;
            ch_reg <= '0; np_reg <= '0; due_reg <= 1'b0; ov_reg <= 1'b0;
            pv_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next; mode_reg <= mode_next; cnt_reg <= cnt_next;
            el_reg <= el_next; len_reg <= len_next; pos_reg <= pos_next;
            pi_reg <= pi_next; ch_reg <= ch_next; np_reg <= np_next;
            due_reg <= due_next; ov_reg <= ov_next; pv_reg <= pv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        or_reg <= or_next;
        pw_reg <= pw_next;
        if (wr_en) store[wr_addr] <= wr_data;
        if (rd_en) rd_reg <= store[pi_reg[ADDR_BITS-1:0]];
    end

    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= EVENT_SLOTS) else $error("note count overflow");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !o_ready) |=> (ov_reg && $stable(or_reg.kind)))
        else $error("result lost under stall");
    a_np: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_PLAY_CHK) |-> (np_reg < PLAY_PER_TICK)) else $error("too many plays");
    a_held: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_IDLE) |-> !pv_reg) else $error("played note left behind");
endmodule

// ===== sv/midi_note_loop_recorder_unit.sv =====
`timescale 1ns / 1ps
// midi looper: a front stage classifies each word, drops cc11 with value 0 and
// unused request codes, and queues the job in a two-word fifo; the back stage
// runs it against the note store (single-port memory, one access a cycle). a
// message or report gives its single word once it is taken; start and stop-loop
// emit 32 all-off words at one per cycle while the output is not stalled; a
// loop tick reads then checks each note played from the store in turn; each
// played note is held back one step so that the final one can carry tlast.
// tlast marks the final word of each input; a tick that plays nothing gives no word.
module midi_note_loop_recorder_unit
    import mlr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [2:0]  s_tuser,   // req_type
    input  logic [23:0] s_tdata,   // msg_type, msg_channel, data_first, data_second
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [1:0]  m_tuser,   // kind
    output logic [31:0] m_tdata,   // out_type, out_channel, out_first, out_second, loop_started, mode_now
    output logic        m_tlast
);
    logic [3:0] ch_reg;
    logic q_valid, q_ready, raw_valid;
    job_t q_job;
    res_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) ch_reg <= 4'd1;
        else if (cfg_we) ch_reg <= cfg_wdata;
    end

    mlr_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(s_tvalid), .in_ready(s_tready),
        .req(s_tuser), .ty(s_tdata[3:0]), .ch(s_tdata[7:4]),
        .a(s_tdata[14:8]), .b(s_tdata[21:15]),
        .q_valid(q_valid), .q_ready(q_ready), .q_job(q_job)
    );

    mlr_back u_back (
        .clk(clk), .rst_n(rst_n), .loop_ch(ch_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_job(q_job),
        .o_valid(raw_valid), .o_ready(m_tready), .o_res(res)
    );

    assign m_tvalid = raw_valid;
    assign m_tuser  = res.kind;
    assign m_tdata  = {7'd0, res.mode, res.started, res.b, res.a, res.ch, res.ty};
    assign m_tlast  = res.last;
endmodule
